[src/round_robin_quantum_dispatcher_unit_assert.svh]
// Assertion macros for the round-robin quantum dispatcher.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef ROUND_ROBIN_QUANTUM_DISPATCHER_UNIT_ASSERT_SVH
`define ROUND_ROBIN_QUANTUM_DISPATCHER_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RRQD_ASSERT_IMPLIES(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("dispatcher assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define RRQD_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("dispatcher assertion failed");

`endif

[src/rrqd_pkg.sv]
// Shared types and constants of the round-robin quantum dispatcher.
// No dependencies; used by the front, back and top-level modules.
package rrqd_pkg;

    localparam int MAX_TASKS     = 32;
    localparam int SLOT_W        = $clog2(MAX_TASKS);
    localparam int CNT_W         = $clog2(MAX_TASKS + 1);
    localparam int TASK_SLOT_W   = 5;
    localparam int BURST_W       = 16;
    localparam int QUANTUM_W     = 16;
    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd10;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic KIND_ADD      = 1'b0;
    localparam logic KIND_DISPATCH = 1'b1;

    typedef enum logic {
        OP_ADD,
        OP_DISPATCH
    } op_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_EXEC
    } back_state_t;

    typedef struct packed {
        logic               kind;
        logic [BURST_W-1:0] burst;
    } req_t;

    typedef struct packed {
        logic [TASK_SLOT_W-1:0] task_slot;
        logic [BURST_W-1:0]     run_time;
        logic                   task_done;
        logic                   none_left;
    } result_t;

    typedef struct packed {
        op_t                op;
        logic [BURST_W-1:0] burst;
    } cmd_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } queue_stat_t;

endpackage

[src/rrqd_front.sv]
// Front end: accepts requests, classifies them into commands and queues them.
// Depends on rrqd_pkg.
module rrqd_front
    import rrqd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  req_t        req,
    input  logic        pop,
    output cmd_t        cmd,
    output queue_stat_t stat
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    cmd_t              classified;
    logic              do_pop;

    always_comb
    begin
        classified.op    = (req.kind == KIND_DISPATCH) ? OP_DISPATCH : OP_ADD;
        classified.burst = req.burst;
    end

    assign stat.not_empty = (count_reg != '0);
    assign stat.full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_pop         = pop && stat.not_empty;
    assign cmd            = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

[src/rrqd_back.sv]
// Back end: task table, round-robin slot search and quantum accounting.
// Depends on rrqd_pkg; fed by rrqd_front.
module rrqd_back
    import rrqd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    input  queue_stat_t          qstat,
    input  logic [QUANTUM_W-1:0] quantum,
    output logic                 pop,
    output logic                 idle,
    output logic                 strobe,
    output result_t              result
);

    back_state_t          state_reg, state_next;
    logic [MAX_TASKS-1:0] occ_reg, occ_next;
    logic [CNT_W-1:0]     next_free_reg, next_free_next;
    logic [SLOT_W-1:0]    sp_reg, sp_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic                 strobe_reg, strobe_next;
    result_t              result_reg, result_next;

    logic [BURST_W-1:0]   burst_mem [MAX_TASKS];
    logic [BURST_W-1:0]   rd_data_reg;
    logic                 mem_we;
    logic [SLOT_W-1:0]    mem_waddr;
    logic [BURST_W-1:0]   mem_wdata;

    logic [MAX_TASKS-1:0] below_mask;
    logic                 found_below, found_any;
    logic [SLOT_W-1:0]    idx_below, idx_any, found_slot;

    // Highest set bit of a vector, with a found flag.
    function automatic logic [SLOT_W:0] highest_set(input logic [MAX_TASKS-1:0] vec);
        logic [SLOT_W:0] res;
        res = '0;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            if (vec[i])
            begin
                res = {1'b1, SLOT_W'(i)};
            end
        end
        return res;
    endfunction

    // Search runs downward from just below the serve pointer, then wraps to the top.
    always_comb
    begin
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            below_mask[i] = occ_reg[i] && (SLOT_W'(i) < sp_reg);
        end
        {found_below, idx_below} = highest_set(below_mask);
        {found_any, idx_any}     = highest_set(occ_reg);
        found_slot = found_below ? idx_below : idx_any;
    end

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        next_free_next = next_free_reg;
        sp_next        = sp_reg;
        slot_next      = slot_reg;
        strobe_next    = 1'b0;
        result_next    = result_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = next_free_reg[SLOT_W-1:0];
        mem_wdata      = cmd.burst;
        case (state_reg)
            BACK_IDLE:
            begin
                if (qstat.not_empty)
                begin
                    pop = 1'b1;
                    case (cmd.op)
                        OP_ADD:
                        begin
                            if (next_free_reg < CNT_W'(MAX_TASKS))
                            begin
                                mem_we = 1'b1;
                                occ_next[next_free_reg[SLOT_W-1:0]] = 1'b1;
                                next_free_next = next_free_reg + 1'b1;
                            end
                        end
                        OP_DISPATCH:
                        begin
                            if (found_any)
                            begin
                                slot_next  = found_slot;
                                state_next = BACK_EXEC;
                            end
                            else
                            begin
                                strobe_next           = 1'b1;
                                result_next.task_slot = '0;
                                result_next.run_time  = '0;
                                result_next.task_done = 1'b0;
                                result_next.none_left = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            BACK_EXEC:
            begin
                mem_we                = 1'b1;
                mem_waddr             = slot_reg;
                sp_next               = slot_reg;
                strobe_next           = 1'b1;
                result_next.task_slot = TASK_SLOT_W'(slot_reg);
                result_next.none_left = 1'b0;
                if (rd_data_reg > quantum)
                begin
                    mem_wdata             = rd_data_reg - quantum;
                    result_next.run_time  = quantum;
                    result_next.task_done = 1'b0;
                end
                else
                begin
                    mem_wdata             = '0;
                    result_next.run_time  = rd_data_reg;
                    result_next.task_done = 1'b1;
                    occ_next[slot_reg]    = 1'b0;
                end
                state_next = BACK_IDLE;
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_IDLE;
            occ_reg       <= '0;
            next_free_reg <= '0;
            sp_reg        <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            next_free_reg <= next_free_next;
            sp_reg        <= sp_next;
            strobe_reg    <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            burst_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= burst_mem[found_slot];
    end

    assign idle   = (state_reg == BACK_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

[src/round_robin_quantum_dispatcher_unit.sv]
// A dispatch request that serves a task goes through the slot search and table read,
// then the table update; when no task remains, the slot search reports it directly.
// Throughput: one add per cycle while the back end is idle; a serving dispatch holds the
// back end through the table read-modify-write; a 2-entry queue absorbs bursts. Results cannot stall.
// Reset (rst_n, async, active low): table empty, pointers zero, quantum back to 10.
// Depends on rrqd_pkg, rrqd_front, rrqd_back and the assertion macro header.
`include "round_robin_quantum_dispatcher_unit_assert.svh"

module round_robin_quantum_dispatcher_unit
    import rrqd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Request channel: accepted when start is high and busy is low.
    input  logic                 start,
    output logic                 busy,
    input  req_t                 req,
    // Result channel: each result is valid for exactly one cycle while strobe is high.
    output logic                 strobe,
    output result_t              result,
    // Quantum register write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [QUANTUM_W-1:0] cfg_data
);

    logic [QUANTUM_W-1:0] quantum_reg;
    logic                 push;
    logic                 pop;
    logic                 back_idle;
    cmd_t                 cmd;
    queue_stat_t          qstat;

    // The queue decouples acceptance from execution, so a new request can be
    // taken while the back end is still working on a dispatch. Busy is raised
    // only when the queue has no free entry.
    assign busy      = qstat.full;
    assign push      = start && !busy;
    // The quantum register can always take a write; software must write it only
    // while the dispatcher is idle, which the block itself does not enforce.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= QUANTUM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            quantum_reg <= cfg_data;
        end
    end

    // Front end: classifies each accepted request into an add or a dispatch
    // command and holds it until the back end is free.
    rrqd_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .req   (req),
        .pop   (pop),
        .cmd   (cmd),
        .stat  (qstat)
    );

    // Back end: owns the task table. An add is finished in the cycle it is
    // popped. A dispatch first searches the occupancy bits for the next slot
    // below the serve pointer (wrapping to the newest) and reads that slot's
    // remaining burst, then updates it in the following cycle.
    rrqd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .qstat   (qstat),
        .quantum (quantum_reg),
        .pop     (pop),
        .idle    (back_idle),
        .strobe  (strobe),
        .result  (result)
    );

    // An empty-table report carries no slot, run time or completion.
    `RRQD_ASSERT_IMPLIES(a_none_left_zero, strobe && result.none_left, result.task_slot == '0 && result.run_time == '0 && !result.task_done)

    // With nothing queued and the back end idle, no result can appear next cycle.
    `RRQD_ASSERT_NEXT(a_no_spurious_result, back_idle && !qstat.not_empty, !strobe)

    // A dispatch in flight blocks the queue from being drained.
    `RRQD_ASSERT_IMPLIES(a_no_pop_while_exec, !back_idle, !pop)

endmodule
